@@ design/gdad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

  // One input item: a start date and a count of days to add.
  typedef struct packed {
    logic [29:0] add_days;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } gdad_in_t;

  // Serial day number, counted from 1 March of year -400.
  typedef logic [30:0] gdad_serial_t;

  // Serial day number split into a 400-year era (offset by one) and its day.
  typedef struct packed {
    logic [12:0] era;
    logic [17:0] doe;
  } gdad_era_t;

  // One result item: the resulting date.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [21:0] year;
  } gdad_out_t;

  localparam logic [14:0] EraYears      = 15'd400;
  localparam logic [17:0] DaysPerEra    = 18'd146097;
  localparam logic [30:0] SerialMin     = 31'd146037;
  localparam logic [11:0] Recip25       = 12'd2621;
  localparam logic [13:0] RecipEra      = 14'd14699;
  localparam logic [7:0]  Recip1460     = 8'd179;
  localparam logic [9:0]  Recip365      = 10'd718;
  localparam logic [17:0] DaysPerCent   = 18'd36524;
  localparam logic [17:0] DaysPer4Years = 18'd1460;
  localparam logic [8:0]  DaysPerYear   = 9'd365;

  // Day of the year, counted from 1 March, on which a month begins.
  // Month index 0 is March and 11 is February.
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/gregorian_date_add_days_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date adder. Each item on the slave stream carries a start date
// and a count of days; the block returns on the master stream the date that
// lies that many days later, under proleptic Gregorian leap rules (year 0 is
// a leap year). Every item gives exactly one result item, in order. The block
// keeps no state between items and accepts one item per clock cycle unless
// a full pipeline is held by the master side. The pipeline has 13 register
// stages: three to turn the date into a serial day number and add the
// count, three to divide that number by the days of a 400-year era, and
// seven to turn the day of the era back into a date. Every stage carries a
// valid bit and its own ready, so a stall on the master side holds the
// results in place while empty stages behind them still take new items. A
// day past the end of its month rolls into the next month, day zero means
// the last day of the previous month, and a month of zero or above twelve
// is taken as January; the earliest possible result is held at 1 January of
// year 0.
module gregorian_date_add_days_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // add_days [29:0], start_day [34:30], start_month [38:35],
  // start_year [52:39], zero [55:53]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // end_day [4:0], end_month [8:5], end_year [30:9], zero [31]
  output logic [31:0]      m_axis_tdata_o
);

  gdad_pkg::gdad_in_t     in_item;
  gdad_pkg::gdad_serial_t ser_data;
  gdad_pkg::gdad_era_t    era_data;
  gdad_pkg::gdad_out_t    out_item;
  logic                   ser_valid;
  logic                   ser_ready;
  logic                   era_valid;
  logic                   era_ready;

  // Unpack the slave data; the pad bits are ignored.
  always_comb begin
    in_item.add_days = s_axis_tdata_i[29:0];
    in_item.day      = s_axis_tdata_i[34:30];
    in_item.month    = s_axis_tdata_i[38:35];
    in_item.year     = s_axis_tdata_i[52:39];
  end

  // Date plus count to a serial day number.
  gdad_to_serial u_to_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (in_item),
    .out_valid_o (ser_valid),
    .out_ready_i (ser_ready),
    .out_data_o  (ser_data)
  );

  // Serial day number to era and day of the era.
  gdad_split_era u_split_era (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ser_valid),
    .in_ready_o  (ser_ready),
    .in_data_i   (ser_data),
    .out_valid_o (era_valid),
    .out_ready_i (era_ready),
    .out_data_o  (era_data)
  );

  // Era and day of the era back to a calendar date; its last stage is the
  // output register.
  gdad_to_date u_to_date (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (era_valid),
    .in_ready_o  (era_ready),
    .in_data_i   (era_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_item)
  );

  assign m_axis_tdata_o = {1'b0, out_item.year, out_item.month, out_item.day};

endmodule

`default_nettype wire

@@ design/gdad_to_serial.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three stages: date to serial day number, plus the count of days.
module gdad_to_serial (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire gdad_pkg::gdad_in_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output gdad_pkg::gdad_serial_t     out_data_o
);

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] vin;

  always_comb begin
    rdy[NumStages-1] = ~v_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign vin = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 1: shift the year by one era so that every value stays positive.
  logic [3:0]  mfix;
  logic        early;
  logic [3:0]  mi;
  logic [14:0] y_full;
  logic [12:0] q4;

  always_comb begin
    mfix   = (in_data_i.month == 4'd0 || in_data_i.month > 4'd12) ? 4'd1 : in_data_i.month;
    early  = (mfix <= 4'd2);
    mi     = early ? (mfix + 4'd9) : (mfix - 4'd3);
    y_full = {1'b0, in_data_i.year} + gdad_pkg::EraYears - {14'd0, early};
    q4     = y_full[14:2];
  end

  logic [22:0] a_y365_q;
  logic [12:0] a_q4_q;
  logic [23:0] a_p25_q;
  logic [8:0]  a_dd_q;
  logic [29:0] a_n_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      a_y365_q <= 23'({8'd0, y_full} * 23'd365);
      a_q4_q   <= q4;
      a_p25_q  <= 24'({11'd0, q4} * 24'(gdad_pkg::Recip25));
      a_dd_q   <= 9'(gdad_pkg::month_start(mi) + {4'd0, in_data_i.day});
      a_n_q    <= in_data_i.add_days;
    end
  end

  // Stage 2: year part of the day number, with the century count corrected.
  logic [7:0]  q25;
  logic [12:0] r25;
  logic [7:0]  c100;
  logic [5:0]  c400;
  logic [22:0] ys;

  always_comb begin
    q25  = a_p25_q[23:16];
    r25  = 13'(a_q4_q - 13'({5'd0, q25} * 13'd25));
    c100 = q25 + {7'd0, (r25 >= 13'd25)};
    c400 = c100[7:2];
    ys   = a_y365_q + {10'd0, a_q4_q} - {15'd0, c100} + {17'd0, c400};
  end

  logic [22:0] b_ys_q;
  logic [8:0]  b_dd_q;
  logic [29:0] b_n_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      b_ys_q <= ys;
      b_dd_q <= a_dd_q;
      b_n_q  <= a_n_q;
    end
  end

  // Stage 3: add the day of the year and the count, and hold at 1 January of year 0.
  logic [30:0] sum;

  always_comb begin
    sum = {8'd0, b_ys_q} + {22'd0, b_dd_q} + {1'b0, b_n_q} - 31'd1;
  end

  gdad_pkg::gdad_serial_t c_s_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      c_s_q <= (sum < gdad_pkg::SerialMin) ? gdad_pkg::SerialMin : sum;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = c_s_q;

endmodule

`default_nettype wire

@@ design/gdad_split_era.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three stages: divide the serial day number by the days of one era.
module gdad_split_era (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire gdad_pkg::gdad_serial_t in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output gdad_pkg::gdad_era_t        out_data_o
);

  localparam int unsigned NumStages = 3;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] vin;

  always_comb begin
    rdy[NumStages-1] = ~v_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign vin = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 1: reciprocal product; the estimate is low by at most one.
  logic [44:0] a_p_q;
  logic [30:0] a_s_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      a_p_q <= 45'({14'd0, in_data_i} * 45'(gdad_pkg::RecipEra));
      a_s_q <= in_data_i;
    end
  end

  // Stage 2: remainder of the estimate.
  logic [12:0] qe;
  logic [30:0] rem;

  always_comb begin
    qe  = a_p_q[43:31];
    rem = 31'(a_s_q - 31'({18'd0, qe} * 31'(gdad_pkg::DaysPerEra)));
  end

  logic [12:0] b_q_q;
  logic [18:0] b_r_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      b_q_q <= qe;
      b_r_q <= rem[18:0];
    end
  end

  // Stage 3: one correction step.
  gdad_pkg::gdad_era_t c_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      if (b_r_q >= {1'b0, gdad_pkg::DaysPerEra}) begin
        c_q.era <= b_q_q + 13'd1;
        c_q.doe <= 18'(b_r_q - {1'b0, gdad_pkg::DaysPerEra});
      end else begin
        c_q.era <= b_q_q;
        c_q.doe <= b_r_q[17:0];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = c_q;

endmodule

`default_nettype wire

@@ design/gdad_to_date.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Seven stages: day of the era back to year, month and day.
module gdad_to_date (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gdad_pkg::gdad_era_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output gdad_pkg::gdad_out_t      out_data_o
);

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] vin;

  always_comb begin
    rdy[NumStages-1] = ~v_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  assign vin = {v_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 1: reciprocal product for the four-year count, centuries by compare.
  logic [2:0] q36;

  always_comb begin
    q36 = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (in_data_i.doe >= 18'(k * gdad_pkg::DaysPerCent)) begin
        q36 = 3'(k);
      end
    end
  end

  logic [12:0] s1_era_q;
  logic [17:0] s1_doe_q;
  logic [24:0] s1_p_q;
  logic [2:0]  s1_q36_q;
  logic        s1_qmax_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      s1_era_q  <= in_data_i.era;
      s1_doe_q  <= in_data_i.doe;
      s1_p_q    <= 25'({7'd0, in_data_i.doe} * 25'(gdad_pkg::Recip1460));
      s1_q36_q  <= q36;
      s1_qmax_q <= (in_data_i.doe == 18'(gdad_pkg::DaysPerEra - 18'd1));
    end
  end

  // Stage 2: correct the four-year count.
  logic [6:0]  qe4;
  logic [17:0] r4;
  logic [6:0]  q4;

  always_comb begin
    qe4 = s1_p_q[24:18];
    r4  = 18'(s1_doe_q - 18'({11'd0, qe4} * gdad_pkg::DaysPer4Years));
    q4  = qe4 + {6'd0, (r4 >= gdad_pkg::DaysPer4Years)};
  end

  logic [12:0] s2_era_q;
  logic [17:0] s2_doe_q;
  logic [6:0]  s2_q4_q;
  logic [2:0]  s2_q36_q;
  logic        s2_qmax_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vin[1]) begin
      s2_era_q  <= s1_era_q;
      s2_doe_q  <= s1_doe_q;
      s2_q4_q   <= q4;
      s2_q36_q  <= s1_q36_q;
      s2_qmax_q <= s1_qmax_q;
    end
  end

  // Stage 3: leap-free day count and its reciprocal product for the year.
  logic [17:0] t;

  always_comb begin
    t = s2_doe_q - {11'd0, s2_q4_q} + {15'd0, s2_q36_q} - {17'd0, s2_qmax_q};
  end

  logic [12:0] s3_era_q;
  logic [17:0] s3_doe_q;
  logic [17:0] s3_t_q;
  logic [26:0] s3_p_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vin[2]) begin
      s3_era_q <= s2_era_q;
      s3_doe_q <= s2_doe_q;
      s3_t_q   <= t;
      s3_p_q   <= 27'({9'd0, t} * 27'(gdad_pkg::Recip365));
    end
  end

  // Stage 4: correct the year of the era.
  logic [8:0]  qy;
  logic [17:0] ry4;
  logic [8:0]  yoe;

  always_comb begin
    qy  = s3_p_q[26:18];
    ry4 = 18'(s3_t_q - 18'({9'd0, qy} * 18'(gdad_pkg::DaysPerYear)));
    yoe = qy + {8'd0, (ry4 >= 18'(gdad_pkg::DaysPerYear))};
  end

  logic [12:0] s4_era_q;
  logic [17:0] s4_doe_q;
  logic [8:0]  s4_yoe_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vin[3]) begin
      s4_era_q <= s3_era_q;
      s4_doe_q <= s3_doe_q;
      s4_yoe_q <= yoe;
    end
  end

  // Stage 5: days before the start of that year within the era.
  logic [1:0]  yc100;
  logic [17:0] yd;

  always_comb begin
    yc100 = 2'd0;
    for (int k = 1; k <= 3; k++) begin
      if (s4_yoe_q >= 9'(k * 100)) begin
        yc100 = 2'(k);
      end
    end
    yd = 18'({9'd0, s4_yoe_q} * 18'(gdad_pkg::DaysPerYear))
       + {11'd0, s4_yoe_q[8:2]} - {16'd0, yc100};
  end

  logic [12:0] s5_era_q;
  logic [17:0] s5_doe_q;
  logic [8:0]  s5_yoe_q;
  logic [17:0] s5_yd_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vin[4]) begin
      s5_era_q <= s4_era_q;
      s5_doe_q <= s4_doe_q;
      s5_yoe_q <= s4_yoe_q;
      s5_yd_q  <= yd;
    end
  end

  // Stage 6: day of the year and the month it falls in.
  logic [8:0] doy;
  logic [3:0] mp;

  always_comb begin
    doy = 9'(s5_doe_q - s5_yd_q);
    mp  = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= gdad_pkg::month_start(4'(k))) begin
        mp = 4'(k);
      end
    end
  end

  logic [12:0] s6_era_q;
  logic [8:0]  s6_yoe_q;
  logic [8:0]  s6_doy_q;
  logic [3:0]  s6_mp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && vin[5]) begin
      s6_era_q <= s5_era_q;
      s6_yoe_q <= s5_yoe_q;
      s6_doy_q <= doy;
      s6_mp_q  <= mp;
    end
  end

  // Stage 7: calendar month, day and year. January and February belong to
  // the following calendar year; the era carries an offset of one.
  logic [3:0]  rm;
  logic [4:0]  rd;
  logic [22:0] ry;

  always_comb begin
    rm = (s6_mp_q < 4'd10) ? (s6_mp_q + 4'd3) : (s6_mp_q - 4'd9);
    rd = 5'(s6_doy_q - gdad_pkg::month_start(s6_mp_q) + 9'd1);
    ry = 23'({10'd0, s6_era_q} * 23'(gdad_pkg::EraYears)) + {14'd0, s6_yoe_q}
       + {22'd0, (rm <= 4'd2)} - 23'(gdad_pkg::EraYears);
  end

  gdad_pkg::gdad_out_t s7_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6] && vin[6]) begin
      s7_q.day   <= rd;
      s7_q.month <= rm;
      s7_q.year  <= ry[21:0];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = s7_q;

endmodule

`default_nettype wire
